// File: rtl/core/sorted_unique_set_table_top_macros.svh
// Assertion macros for the checker of the sorted set table.
// No dependencies; included by the checker file by its bare name.
`ifndef SORTED_UNIQUE_SET_TABLE_TOP_MACROS_SVH
`define SORTED_UNIQUE_SET_TABLE_TOP_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define SUST_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the following cycle.
`define SUST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/sust_pkg.sv
// Package for the sorted set table: sizes, request codes and cell command type.
// No dependencies; imported by every module of the block.
package sust_pkg;

    localparam int CAPACITY    = 64;
    localparam int DATA_W      = 32;
    localparam int REQ_W       = 2;
    localparam int COUNT_OUT_W = 7;
    localparam int CNT_W       = $clog2(CAPACITY + 1);

    // Request codes carried in the request type field.
    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_QUERY  = 2'd2,
        REQ_CLEAR  = 2'd3
    } t_req;

    // Command broadcast from the controller to every cell of the row.
    typedef struct packed {
        logic compare;     // capture the compare flags against the request value
        logic shift_up;    // open a slot and insert the request value
        logic shift_down;  // close the slot of the matching entry
    } t_cell_cmd;

endpackage

// File: rtl/core/sorted_unique_set_table_top.sv
// Sorted set table: keeps up to CAPACITY distinct signed 32-bit values in
// ascending order in a row of cells, one value per cell. Each request word
// inserts, deletes, looks up or clears, and yields one result word with a
// success flag, a full flag and the count after the request. An item passes
// through three states: idle, in which it is accepted; compare, in which
// every cell compares its entry with the request value; and update, in
// which the row shifts and the result is registered. The next item is
// accepted only once the block is back in idle, so it takes no new item
// before it is through with the last one. The result sits in an output
// register, so a waiting result holds up only the update of the next item.
// Reset empties the set at once; no clearing pass runs.
// Depends on sust_pkg and sust_cell.
module sorted_unique_set_table_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [sust_pkg::REQ_W-1:0]          i_req_type,
    input  logic signed [sust_pkg::DATA_W-1:0]  i_item_value,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_success,
    output logic                                o_table_full,
    output logic [sust_pkg::COUNT_OUT_W-1:0]    o_entry_count
);
    import sust_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'b001,
        ST_COMPARE = 3'b010,
        ST_UPDATE  = 3'b100
    } t_state;

    t_state                   r_state;
    t_state                   n_state;
    t_req                     r_req;
    logic signed [DATA_W-1:0] r_item;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic                     r_out_valid;
    logic                     r_success;
    logic                     r_table_full;
    logic [COUNT_OUT_W-1:0]   r_out_count;

    logic                     w_accept;
    logic                     w_advance;
    logic                     w_hit;
    logic                     w_full;
    logic                     w_success;
    logic                     w_table_full;
    t_cell_cmd                w_cmd;

    logic signed [DATA_W-1:0] w_val [CAPACITY];
    logic [CAPACITY-1:0]      w_after;
    logic [CAPACITY-1:0]      w_match;
    logic [CAPACITY-1:0]      w_in_use;

    // Handshake: a word is taken only in idle; the update waits for room
    // in the output register.
    assign o_in_stall = (r_state != ST_IDLE);
    assign w_accept   = i_in_valid && (r_state == ST_IDLE);
    assign w_advance  = (r_state == ST_UPDATE) && (!r_out_valid || !i_out_stall);

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:    if (w_accept) n_state = ST_COMPARE;
            ST_COMPARE: n_state = ST_UPDATE;
            ST_UPDATE:  if (w_advance) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req  <= t_req'(i_req_type);
            r_item <= i_item_value;
        end
    end

    // Decision from the registered cell flags.
    assign w_hit  = |w_match;
    assign w_full = (r_count == CNT_W'(CAPACITY));

    always_comb begin
        w_success    = 1'b0;
        w_table_full = 1'b0;
        n_count      = r_count;
        unique case (r_req)
            REQ_INSERT: begin
                w_success    = !w_hit && !w_full;
                w_table_full = !w_hit && w_full;
                if (!w_hit && !w_full) n_count = r_count + CNT_W'(1);
            end
            REQ_DELETE: begin
                w_success = w_hit;
                if (w_hit) n_count = r_count - CNT_W'(1);
            end
            REQ_QUERY: begin
                w_success = w_hit;
            end
            REQ_CLEAR: begin
                w_success = 1'b1;
                n_count   = '0;
            end
            default: begin
                w_success = 1'b0;
            end
        endcase
    end

    // Command to the row.
    always_comb begin
        w_cmd            = '0;
        w_cmd.compare    = (r_state == ST_COMPARE);
        w_cmd.shift_up   = w_advance && (r_req == REQ_INSERT) && !w_hit && !w_full;
        w_cmd.shift_down = w_advance && (r_req == REQ_DELETE) && w_hit;
    end

    // Entry count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_advance) begin
            r_count <= n_count;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_success    <= w_success;
            r_table_full <= w_table_full;
            r_out_count  <= COUNT_OUT_W'(n_count);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_success     = r_success;
    assign o_table_full  = r_table_full;
    assign o_entry_count = r_out_count;

    // Row of cells, each linked to its neighbors.
    for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
        logic signed [DATA_W-1:0] w_left_val;
        logic                     w_left_after;
        logic signed [DATA_W-1:0] w_right_val;

        assign w_in_use[j] = (CNT_W'(j) < r_count);

        if (j == 0) begin : g_first
            assign w_left_val   = '0;
            assign w_left_after = 1'b0;
        end else begin : g_inner_left
            assign w_left_val   = w_val[j-1];
            assign w_left_after = w_after[j-1];
        end

        if (j == CAPACITY - 1) begin : g_last
            assign w_right_val = w_val[j];
        end else begin : g_inner_right
            assign w_right_val = w_val[j+1];
        end

        sust_cell u_cell (
            .i_clk        (i_clk),
            .i_cmd        (w_cmd),
            .i_item       (r_item),
            .i_in_use     (w_in_use[j]),
            .i_left_val   (w_left_val),
            .i_left_after (w_left_after),
            .i_right_val  (w_right_val),
            .o_val        (w_val[j]),
            .o_after      (w_after[j]),
            .o_match      (w_match[j])
        );
    end

endmodule

// File: rtl/core/sust_cell.sv
// One cell of the sorted row: holds one entry and its compare flags.
// Depends on sust_pkg; instantiated in a row by sorted_unique_set_table_top.
module sust_cell (
    input  logic                                i_clk,
    input  sust_pkg::t_cell_cmd                 i_cmd,
    input  logic signed [sust_pkg::DATA_W-1:0]  i_item,
    input  logic                                i_in_use,
    input  logic signed [sust_pkg::DATA_W-1:0]  i_left_val,
    input  logic                                i_left_after,
    input  logic signed [sust_pkg::DATA_W-1:0]  i_right_val,
    output logic signed [sust_pkg::DATA_W-1:0]  o_val,
    output logic                                o_after,
    output logic                                o_match
);
    import sust_pkg::*;

    logic signed [DATA_W-1:0] r_val;
    logic signed [DATA_W-1:0] n_val;
    logic                     r_after;
    logic                     r_match;

    // A cell lies at or after the insertion point when it is unused or its
    // entry is not below the request value. Along the row these flags are
    // monotone, so the first set flag marks the insertion point.
    always_ff @(posedge i_clk) begin
        if (i_cmd.compare) begin
            r_after <= !i_in_use || (r_val >= i_item);
            r_match <= i_in_use && (r_val == i_item);
        end
    end

    // Shift step: on insert every cell past the point takes its left
    // neighbor and the cell at the point takes the new value; on delete
    // every cell from the match on takes its right neighbor.
    always_comb begin
        n_val = r_val;
        if (i_cmd.shift_up && r_after) begin
            n_val = i_left_after ? i_left_val : i_item;
        end else if (i_cmd.shift_down && r_after) begin
            n_val = i_right_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val   = r_val;
    assign o_after = r_after;
    assign o_match = r_match;

endmodule

// File: rtl/core/sust_checker.sv
// Port-level checker for the sorted set table, bound to the top level.
// Depends on sust_pkg and sorted_unique_set_table_top_macros.svh.
`include "sorted_unique_set_table_top_macros.svh"

module sust_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                o_in_stall,
    input  logic [sust_pkg::REQ_W-1:0]          i_req_type,
    input  logic signed [sust_pkg::DATA_W-1:0]  i_item_value,
    input  logic                                o_out_valid,
    input  logic                                i_out_stall,
    input  logic                                o_success,
    input  logic                                o_table_full,
    input  logic [sust_pkg::COUNT_OUT_W-1:0]    o_entry_count
);
    import sust_pkg::*;

    // A stalled request word stays valid and holds its payload.
    `SUST_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_in_valid && o_in_stall, i_in_valid && $stable(i_req_type) && $stable(i_item_value), "request word changed while stalled")

    // A stalled result word holds its payload.
    `SUST_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_success) && $stable(o_table_full) && $stable(o_entry_count), "result word changed while stalled")

    // A refused insert into a full table never also reports success.
    `SUST_ASSERT_NOW(a_full_not_ok, i_clk, i_rst_n, o_out_valid && o_table_full, !o_success, "full flag together with success")

    // The full flag only appears when the table holds its whole capacity.
    `SUST_ASSERT_NOW(a_full_count, i_clk, i_rst_n, o_out_valid && o_table_full, o_entry_count == COUNT_OUT_W'(CAPACITY), "full flag with a count below capacity")

    // One word at a time: an accepted word blocks the input in the next cycle.
    `SUST_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "input taken again right after a word")

endmodule

bind sorted_unique_set_table_top sust_checker u_sust_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .i_req_type    (i_req_type),
    .i_item_value  (i_item_value),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_success     (o_success),
    .o_table_full  (o_table_full),
    .o_entry_count (o_entry_count)
);

// File: dv/sorted_unique_set_table_top_tb.sv
// Testbench for sorted_unique_set_table_top: a directed table of requests and then random
// fill, drain and mixed traffic, checked word by word against fixed answers or a sorted-queue predictor.
// Depends on sust_pkg and the RTL of the sorted set table.
module sorted_unique_set_table_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sust_pkg::*;

    localparam int RANDOM_ITEMS   = 1150;
    localparam int DIRECTED_COUNT = 23;
    localparam int PHASE_ITEMS    = 80;

    // Result word as the block presents it.
    typedef struct packed {
        logic                   success;
        logic                   full;
        logic [COUNT_OUT_W-1:0] count;
    } t_set_result;

    typedef struct {
        t_req                     req;
        logic signed [DATA_W-1:0] value;
        bit                       fixed_answer;
        t_set_result              answer;
    } t_directed_row;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic [REQ_W-1:0]           i_req_type;
    logic signed [DATA_W-1:0]   i_item_value;
    logic                       o_out_valid;
    logic                       i_out_stall;
    logic                       o_success;
    logic                       o_table_full;
    logic [COUNT_OUT_W-1:0]     o_entry_count;

    // Predictor state: the stored values in ascending order.
    logic signed [DATA_W-1:0] shadow_set[$];
    t_set_result              awaited_results[$];
    int                       error_count;
    int                       words_sent;
    int                       send_idle_pct;
    int                       recv_stall_pct;

    // Values that sit on the ordering boundaries and near zero.
    logic signed [DATA_W-1:0] corner_values [12] = '{
        32'sh80000000, 32'sh7FFFFFFF, 32'sh00000000, 32'shFFFFFFFF,
        32'sh00000001, 32'sh00000002, 32'shFFFFFFFE, 32'sh7FFFFFFE,
        32'sh80000001, 32'sh00000064, 32'shFFFFFF9C, 32'sh12345678
    };

    // Directed requests; rows with a fixed answer carry it, the rest use the predictor.
    t_directed_row directed_rows [DIRECTED_COUNT] = '{
        '{REQ_QUERY,  32'sh00000000, 1'b1, '{1'b0, 1'b0, 7'd0}},
        '{REQ_DELETE, 32'sh00000005, 1'b1, '{1'b0, 1'b0, 7'd0}},
        '{REQ_INSERT, 32'sh80000000, 1'b1, '{1'b1, 1'b0, 7'd1}},
        '{REQ_INSERT, 32'sh7FFFFFFF, 1'b1, '{1'b1, 1'b0, 7'd2}},
        '{REQ_INSERT, 32'sh00000000, 1'b1, '{1'b1, 1'b0, 7'd3}},
        '{REQ_INSERT, 32'shFFFFFFFF, 1'b1, '{1'b1, 1'b0, 7'd4}},
        '{REQ_INSERT, 32'sh00000001, 1'b1, '{1'b1, 1'b0, 7'd5}},
        '{REQ_INSERT, 32'sh80000000, 1'b1, '{1'b0, 1'b0, 7'd5}},
        '{REQ_QUERY,  32'sh7FFFFFFF, 1'b1, '{1'b1, 1'b0, 7'd5}},
        '{REQ_QUERY,  32'sh00000002, 1'b1, '{1'b0, 1'b0, 7'd5}},
        '{REQ_DELETE, 32'shFFFFFFFF, 1'b1, '{1'b1, 1'b0, 7'd4}},
        '{REQ_DELETE, 32'shFFFFFFFF, 1'b1, '{1'b0, 1'b0, 7'd4}},
        '{REQ_QUERY,  32'shFFFFFFFF, 1'b1, '{1'b0, 1'b0, 7'd4}},
        '{REQ_DELETE, 32'sh80000000, 1'b1, '{1'b1, 1'b0, 7'd3}},
        '{REQ_DELETE, 32'sh7FFFFFFF, 1'b1, '{1'b1, 1'b0, 7'd2}},
        '{REQ_INSERT, 32'sh80000001, 1'b0, '{1'b0, 1'b0, 7'd0}},
        '{REQ_INSERT, 32'sh7FFFFFFE, 1'b0, '{1'b0, 1'b0, 7'd0}},
        '{REQ_QUERY,  32'sh80000001, 1'b0, '{1'b0, 1'b0, 7'd0}},
        '{REQ_CLEAR,  32'shFFFFFFFF, 1'b1, '{1'b1, 1'b0, 7'd0}},
        '{REQ_QUERY,  32'sh00000000, 1'b1, '{1'b0, 1'b0, 7'd0}},
        '{REQ_INSERT, 32'sh55555555, 1'b0, '{1'b0, 1'b0, 7'd0}},
        '{REQ_INSERT, 32'shAAAAAAAA, 1'b0, '{1'b0, 1'b0, 7'd0}},
        '{REQ_CLEAR,  32'sh00000000, 1'b1, '{1'b1, 1'b0, 7'd0}}
    };

    sorted_unique_set_table_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_item_value  (i_item_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_success     (o_success),
        .o_table_full  (o_table_full),
        .o_entry_count (o_entry_count)
    );

    // Clock with a 10 ns period.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Applies one request to the shadow set and returns the result word it should give.
    function automatic t_set_result apply_set_request(input t_req req,
                                                      input logic signed [DATA_W-1:0] value);
        t_set_result res;
        int          pos;
        bit          hit;
        res = '0;
        pos = 0;
        while (pos < shadow_set.size() && shadow_set[pos] < value) pos++;
        hit = (pos < shadow_set.size()) && (shadow_set[pos] == value);
        case (req)
            REQ_CLEAR: begin
                shadow_set.delete();
                res.success = 1'b1;
            end
            REQ_QUERY: begin
                res.success = hit;
            end
            REQ_DELETE: begin
                if (hit) begin
                    shadow_set.delete(pos);
                    res.success = 1'b1;
                end
            end
            default: begin
                // Duplicates are refused without the full flag, even in a full table.
                if (!hit) begin
                    if (shadow_set.size() >= CAPACITY) begin
                        res.full = 1'b1;
                    end else begin
                        shadow_set.insert(pos, value);
                        res.success = 1'b1;
                    end
                end
            end
        endcase
        res.count = COUNT_OUT_W'(shadow_set.size());
        return res;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("mismatch at %0t: %s got %0d, expected %0d", $time, field, got, want);
        error_count++;
    endtask

    // Sends one request word; the expectation is queued at the edge where it is accepted.
    task automatic send_request(input t_req req, input logic signed [DATA_W-1:0] value,
                                input bit fixed_answer, input t_set_result answer);
        t_set_result predicted;
        // The idling pattern moves through its phases as the run goes on.
        case ((words_sent / PHASE_ITEMS) % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
            default: begin send_idle_pct = 16; recv_stall_pct = 16; end
        endcase
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_req_type   <= req;
        i_item_value <= value;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predicted = apply_set_request(req, value);
        awaited_results.push_back(fixed_answer ? answer : predicted);
        words_sent++;
        @(negedge i_clk);
    endtask

    // Picks a value: a fresh random one, one already stored, or a corner value.
    function automatic logic signed [DATA_W-1:0] pick_value(input int fresh_pct,
                                                            input int stored_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < fresh_pct || (roll < fresh_pct + stored_pct && shadow_set.size() == 0))
            return $urandom;
        if (roll < fresh_pct + stored_pct)
            return shadow_set[$urandom_range(0, shadow_set.size() - 1)];
        return corner_values[$urandom_range(0, 11)];
    endfunction

    // Receiver stall, changed at the falling edge.
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Checks each accepted result word against the oldest expectation.
    always @(posedge i_clk) begin
        t_set_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("unexpected result word", 1, 0);
            end else begin
                want = awaited_results.pop_front();
                if (o_success !== want.success)
                    report_mismatch("success", o_success, want.success);
                if (o_table_full !== want.full)
                    report_mismatch("table_full", o_table_full, want.full);
                if (o_entry_count !== want.count)
                    report_mismatch("entry_count", o_entry_count, want.count);
            end
        end
    end

    // Run limit, far above the slowest correct run.
    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int          random_sent;
        int          episode_kind;
        int          episode_len;
        int          ins_pct;
        int          del_pct;
        int          qry_pct;
        int          roll;
        t_req        req;
        logic signed [DATA_W-1:0] value;
        random_sent    = 0;
        error_count    = 0;
        words_sent     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_req_type     = REQ_QUERY;
        i_item_value   = '0;
        i_out_stall    = 1'b0;
        // Hold reset, then release it at a falling edge.
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part.
        for (int r = 0; r < DIRECTED_COUNT; r++) begin
            send_request(directed_rows[r].req, directed_rows[r].value,
                         directed_rows[r].fixed_answer, directed_rows[r].answer);
        end

        // Random part in episodes: fill toward a full table, drain, or mixed traffic.
        while (random_sent < RANDOM_ITEMS) begin
            episode_kind = $urandom_range(0, 4);
            if (episode_kind <= 1) begin
                episode_len = $urandom_range(110, 180);
                ins_pct = 75; del_pct = 8;  qry_pct = 17;
            end else if (episode_kind == 2) begin
                episode_len = $urandom_range(30, 120);
                ins_pct = 15; del_pct = 60; qry_pct = 23;
            end else begin
                episode_len = $urandom_range(20, 100);
                ins_pct = 35; del_pct = 30; qry_pct = 30;
            end
            for (int k = 0; k < episode_len && random_sent < RANDOM_ITEMS; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < ins_pct) begin
                    req   = REQ_INSERT;
                    value = (episode_kind <= 1) ? pick_value(80, 10) : pick_value(50, 25);
                end else if (roll < ins_pct + del_pct) begin
                    req   = REQ_DELETE;
                    value = pick_value(25, 55);
                end else if (roll < ins_pct + del_pct + qry_pct) begin
                    req   = REQ_QUERY;
                    value = pick_value(25, 55);
                end else begin
                    req   = REQ_CLEAR;
                    value = $urandom;
                end
                send_request(req, value, 1'b0, '0);
                random_sent++;
            end
        end
        i_in_valid <= 1'b0;

        // Drain the outstanding results, then keep watching for stray words.
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
